// ===== rtl/core/pbc_pkg.sv =====
// ---------------------------------------------------------------------------
// pbc_pkg
// Shared types, widths and codes of the pileup base counter: counter width,
// base index codes and the action record passed from front to back.
// ---------------------------------------------------------------------------
package pbc_pkg;

   localparam int COUNT_WIDTH = 16;
   localparam int OUT_WIDTH   = 16;
   localparam int NUM_COUNTS  = 5;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
   localparam logic [OUT_WIDTH-1:0]   OUT_MAX   = {OUT_WIDTH{1'b1}};

   // counter index codes
   localparam logic [2:0] IDX_A     = 3'd0;
   localparam logic [2:0] IDX_C     = 3'd1;
   localparam logic [2:0] IDX_G     = 3'd2;
   localparam logic [2:0] IDX_T     = 3'd3;
   localparam logic [2:0] IDX_OTHER = 3'd4;

   // one classified character: which counter to bump, and end of string
   typedef struct packed {
      logic       bump;
      logic [2:0] idx;
      logic       last;
   } pbc_action_type;

   function automatic logic [OUT_WIDTH-1:0] sat_out(input logic [COUNT_WIDTH-1:0] v);
      logic [31:0] w;
      w = 32'(v);
      if (w > 32'(OUT_MAX)) begin
         return OUT_MAX;
      end
      return w[OUT_WIDTH-1:0];
   endfunction

endpackage

// ===== rtl/core/pbc_front.sv =====
// ---------------------------------------------------------------------------
// pbc_front
// Scanner for the pileup base string: tracks skip and indel modes, and turns
// each accepted character into an action for the counting back end.
// ---------------------------------------------------------------------------
module pbc_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_char_byte,
   input  logic [2:0]             req_ref_code,
   input  logic                   req_last_char,
   output logic                   push_valid,
   input  logic                   push_ready,
   output pbc_pkg::pbc_action_type push_data
);

   typedef enum logic [1:0] {
      MODE_NORMAL,
      MODE_SKIP1,
      MODE_DIGITS,
      MODE_INDEL
   } mode_type;

   localparam logic [7:0] CH_CARET  = 8'h5E;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;

   localparam int LEN_WIDTH = 16;
   localparam int PROD_WIDTH = LEN_WIDTH + 4;
   localparam logic [LEN_WIDTH-1:0] LEN_MAX = {LEN_WIDTH{1'b1}};

   mode_type              mode_ff, mode_in;
   logic [LEN_WIDTH-1:0]  rem_ff, rem_in;
   logic                  accept;
   logic                  is_digit;
   logic [PROD_WIDTH-1:0] len_next;
   logic [LEN_WIDTH-1:0]  rem_dec;
   logic                  bump;
   logic [2:0]            idx;

   function automatic logic [2:0] letter_code(input logic [7:0] c);
      logic [2:0] r;
      r = pbc_pkg::IDX_OTHER;
      if (c inside {8'h41, 8'h61}) r = pbc_pkg::IDX_A;
      if (c inside {8'h43, 8'h63}) r = pbc_pkg::IDX_C;
      if (c inside {8'h47, 8'h67}) r = pbc_pkg::IDX_G;
      if (c inside {8'h54, 8'h74}) r = pbc_pkg::IDX_T;
      return r;
   endfunction

   assign accept     = req_valid && push_ready;
   assign req_ready  = push_ready;
   assign push_valid = req_valid;
   assign push_data  = '{bump: bump, idx: idx, last: req_last_char};

   assign is_digit = req_char_byte inside {[CH_ZERO:CH_NINE]};
   // len * 10 + digit, as two shifts and adds
   assign len_next = (PROD_WIDTH'(rem_ff) << 3) + (PROD_WIDTH'(rem_ff) << 1)
                   + PROD_WIDTH'(req_char_byte - CH_ZERO);
   assign rem_dec  = rem_ff - LEN_WIDTH'(1);

   always_comb begin
      logic run_normal;
      mode_in    = mode_ff;
      rem_in     = rem_ff;
      bump       = 1'b0;
      idx        = pbc_pkg::IDX_OTHER;
      run_normal = 1'b0;
      case (mode_ff)
         MODE_SKIP1: begin
            mode_in = MODE_NORMAL;
         end
         MODE_DIGITS: begin
            if (is_digit) begin
               rem_in = (len_next > PROD_WIDTH'(LEN_MAX)) ? LEN_MAX
                                                          : len_next[LEN_WIDTH-1:0];
            end else if (rem_ff == '0) begin
               mode_in    = MODE_NORMAL;
               run_normal = 1'b1;
            end else begin
               // this character is the first one of the indel
               rem_in  = rem_dec;
               mode_in = (rem_dec != '0) ? MODE_INDEL : MODE_NORMAL;
            end
         end
         MODE_INDEL: begin
            if (rem_ff != '0) begin
               rem_in = rem_dec;
            end
            if (rem_ff <= LEN_WIDTH'(1)) begin
               mode_in = MODE_NORMAL;
            end
         end
         default: begin
            run_normal = 1'b1;
         end
      endcase

      if (run_normal) begin
         if (req_char_byte == CH_CARET) begin
            mode_in = MODE_SKIP1;
         end else if (req_char_byte inside {CH_DOLLAR, CH_STAR}) begin
            bump = 1'b0;
         end else if (req_char_byte inside {CH_PLUS, CH_MINUS}) begin
            mode_in = MODE_DIGITS;
            rem_in  = '0;
         end else if (req_char_byte inside {CH_DOT, CH_COMMA}) begin
            bump = 1'b1;
            idx  = (req_ref_code > pbc_pkg::IDX_OTHER) ? pbc_pkg::IDX_OTHER : req_ref_code;
         end else begin
            bump = 1'b1;
            idx  = letter_code(req_char_byte);
         end
      end

      // end of string drops any pending skip
      if (req_last_char) begin
         mode_in = MODE_NORMAL;
         rem_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_NORMAL;
         rem_ff  <= '0;
      end else if (accept) begin
         mode_ff <= mode_in;
         rem_ff  <= rem_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_indel_nonzero: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_INDEL |-> rem_ff != '0)
      else $error("indel mode with nothing left to skip");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_last_char |=> mode_ff == MODE_NORMAL && rem_ff == '0)
      else $error("scan state not cleared after last character");
`endif

endmodule

// ===== rtl/core/pbc_queue.sv =====
// ---------------------------------------------------------------------------
// pbc_queue
// Short FIFO of classified actions between the scanner and the counters.
// ---------------------------------------------------------------------------
module pbc_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_valid,
   output logic                    push_ready,
   input  pbc_pkg::pbc_action_type push_data,
   output logic                    pop_valid,
   input  logic                    pop_ready,
   output pbc_pkg::pbc_action_type pop_data
);

   localparam int PTR_W = $clog2(pbc_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(pbc_pkg::QUEUE_DEPTH + 1);

   pbc_pkg::pbc_action_type entry_ff [pbc_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   logic             pop;

   assign push_ready = count_ff != CNT_W'(pbc_pkg::QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(pbc_pkg::QUEUE_DEPTH)
      && (wr_ptr_ff - rd_ptr_ff) == count_ff[PTR_W-1:0])
      else $error("queue fill count out of step with pointers");
`endif

endmodule

// ===== rtl/core/pbc_back.sv =====
// ---------------------------------------------------------------------------
// pbc_back
// Counting back end: five saturating base counters and the result register.
// ---------------------------------------------------------------------------
module pbc_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    pop_valid,
   output logic                    pop_ready,
   input  pbc_pkg::pbc_action_type pop_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [15:0]             rsp_count_a,
   output logic [15:0]             rsp_count_c,
   output logic [15:0]             rsp_count_g,
   output logic [15:0]             rsp_count_t,
   output logic [15:0]             rsp_count_other
);

   logic [pbc_pkg::COUNT_WIDTH-1:0] cnt_ff [pbc_pkg::NUM_COUNTS];
   logic [pbc_pkg::COUNT_WIDTH-1:0] cnt_in [pbc_pkg::NUM_COUNTS];
   logic [pbc_pkg::COUNT_WIDTH-1:0] cnt_sum [pbc_pkg::NUM_COUNTS];
   logic [pbc_pkg::OUT_WIDTH-1:0]   out_ff [pbc_pkg::NUM_COUNTS];
   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            pop;
   logic                            emit;

   // a last action waits while an unread result still sits in the register
   assign pop_ready = !pop_data.last || !rsp_valid_ff || rsp_ready;
   assign pop       = pop_valid && pop_ready;
   assign emit      = pop && pop_data.last;

   always_comb begin
      for (int i = 0; i < pbc_pkg::NUM_COUNTS; i++) begin
         cnt_sum[i] = cnt_ff[i];
         if (pop && pop_data.bump && pop_data.idx == 3'(i)
             && cnt_ff[i] != pbc_pkg::COUNT_MAX) begin
            cnt_sum[i] = cnt_ff[i] + pbc_pkg::COUNT_WIDTH'(1);
         end
         cnt_in[i] = emit ? '0 : cnt_sum[i];
      end
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < pbc_pkg::NUM_COUNTS; i++) begin
            cnt_ff[i] <= '0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < pbc_pkg::NUM_COUNTS; i++) begin
            cnt_ff[i] <= cnt_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         for (int i = 0; i < pbc_pkg::NUM_COUNTS; i++) begin
            out_ff[i] <= pbc_pkg::sat_out(cnt_sum[i]);
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_count_a     = out_ff[pbc_pkg::IDX_A];
   assign rsp_count_c     = out_ff[pbc_pkg::IDX_C];
   assign rsp_count_g     = out_ff[pbc_pkg::IDX_G];
   assign rsp_count_t     = out_ff[pbc_pkg::IDX_T];
   assign rsp_count_other = out_ff[pbc_pkg::IDX_OTHER];

`ifndef NO_ASSERTIONS
   a_emit_clears: assert property (@(posedge clock) disable iff (reset)
      emit |=> rsp_valid_ff && cnt_ff[pbc_pkg::IDX_A] == '0 && cnt_ff[pbc_pkg::IDX_C] == '0
      && cnt_ff[pbc_pkg::IDX_G] == '0 && cnt_ff[pbc_pkg::IDX_T] == '0
      && cnt_ff[pbc_pkg::IDX_OTHER] == '0)
      else $error("result not raised or counters not cleared at end of string");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |-> !emit)
      else $error("pending result overwritten");
`endif

endmodule

// ===== rtl/core/pileup_base_counter.sv =====
// ---------------------------------------------------------------------------
// pileup_base_counter
// Counts A, C, G, T and other calls in a pileup read-base string.
// ---------------------------------------------------------------------------
// Usage:
//   Send the base string one character per transfer on the req_ channel,
//   with the reference base code for '.' and ',' and req_last_char set on
//   the final character. After that character the rsp_ channel carries one
//   transfer with the five saturating counts; no other character produces
//   a result.
//   Throughput is one character per cycle while the action queue has room.
//   A character is scanned in the same cycle it is accepted and is written
//   into the queue; the counters take it from the queue head, and popping
//   the last character loads the result register and raises rsp_valid.
//   A four-entry action queue sits between the scanner and the counters.
//   While rsp_ready is low the pending result holds in its register and
//   later characters still go in; once a second end of string waits at the
//   head of the queue, the queue fills behind it and req_ready drops.
//   Reset clears the scan mode, the indel length, the counters and the
//   queue; the block is ready in the first cycle after reset.
// ---------------------------------------------------------------------------
module pileup_base_counter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_byte,
   input  logic [2:0]  req_ref_code,
   input  logic        req_last_char,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_count_a,
   output logic [15:0] rsp_count_c,
   output logic [15:0] rsp_count_g,
   output logic [15:0] rsp_count_t,
   output logic [15:0] rsp_count_other
);

   logic                    push_valid;
   logic                    push_ready;
   pbc_pkg::pbc_action_type push_data;
   logic                    pop_valid;
   logic                    pop_ready;
   pbc_pkg::pbc_action_type pop_data;

   pbc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_char_byte (req_char_byte),
      .req_ref_code  (req_ref_code),
      .req_last_char (req_last_char),
      .push_valid    (push_valid),
      .push_ready    (push_ready),
      .push_data     (push_data)
   );

   pbc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   pbc_back u_back (
      .clock           (clock),
      .reset           (reset),
      .pop_valid       (pop_valid),
      .pop_ready       (pop_ready),
      .pop_data        (pop_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_count_a     (rsp_count_a),
      .rsp_count_c     (rsp_count_c),
      .rsp_count_g     (rsp_count_g),
      .rsp_count_t     (rsp_count_t),
      .rsp_count_other (rsp_count_other)
   );

endmodule
